@@ rtl/macs_pkg.sv @@
package macs_pkg;

    // Field widths of the request and response payloads.
    localparam int REQ_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int VALUE_W  = 24;

    // Divider: a 48-bit dividend whose upper half is below the divisor,
    // so the quotient always fits in 24 bits.
    localparam int DIVD_W = 48;
    localparam int DIVS_W = 25;
    localparam int QUO_W  = 24;

    // Default window depth.
    localparam int NUM_SAMPLES_DEFAULT = 16;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CAP_MIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAP_MAX = 2'd2;

    // Response kinds.
    localparam logic [REQ_W-1:0] KIND_DATA = 2'd0;
    localparam logic [REQ_W-1:0] KIND_MIN  = 2'd1;
    localparam logic [REQ_W-1:0] KIND_MAX  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OUT_MIN = 1'b0;
    localparam logic CFG_OUT_MAX = 1'b1;

    // Reset values of the calibration and output range.
    localparam logic signed [VALUE_W-1:0] CAL_MIN_RESET = 24'sd0;
    localparam logic signed [VALUE_W-1:0] CAL_MAX_RESET = 24'sd1048576;
    localparam logic signed [CFG_W-1:0]   OUT_MIN_RESET = 16'sd0;
    localparam logic signed [CFG_W-1:0]   OUT_MAX_RESET = 16'sd32767;

    typedef struct packed {
        logic [REQ_W-1:0]           req_type;
        logic signed [SAMPLE_W-1:0] sample;
    } req_t;

    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic signed [VALUE_W-1:0] value;
        logic                      order_warning;
    } rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic             rem_nz;
    } div_sts_t;

    typedef struct packed {
        logic                       rd;
        logic                       wr;
        logic signed [SAMPLE_W-1:0] sample;
    } win_ctl_t;

endpackage

@@ rtl/macs_div.sv @@
module macs_div (
    input  logic                clk,
    input  logic                rst_n,
    input  macs_pkg::div_ctl_t  ctl,
    output macs_pkg::div_sts_t  sts
);
    import macs_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  shf_reg, shf_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   part;
    logic [DIVS_W:0]   trial;

    // One restoring step per cycle: the shift register feeds dividend bits in
    // at the top and collects quotient bits at the bottom.
    always_comb
    begin
        part      = {rem_reg, shf_reg[QUO_W-1]};
        trial     = part - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = {1'b0, ctl.dividend[DIVD_W-1:QUO_W]};
            shf_next  = ctl.dividend[QUO_W-1:0];
            dvs_next  = ctl.divisor;
            cnt_next  = CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVS_W])
            begin
                rem_next = trial[DIVS_W-1:0];
            end
            else
            begin
                rem_next = part[DIVS_W-1:0];
            end
            shf_next = {shf_reg[QUO_W-2:0], ~trial[DIVS_W]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        dvs_reg <= dvs_next;
    end

    // Step counter and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign sts.busy     = busy_reg;
    assign sts.done     = done_reg;
    assign sts.quotient = shf_reg;
    assign sts.rem_nz   = |rem_reg;

endmodule

@@ rtl/macs_window.sv @@
module macs_window #(
    parameter int NUM_SAMPLES = macs_pkg::NUM_SAMPLES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  macs_pkg::win_ctl_t  ctl,
    output logic signed [macs_pkg::SAMPLE_W+$clog2(NUM_SAMPLES)-1:0] sum
);
    import macs_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(NUM_SAMPLES);
    localparam int PTR_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int LAST  = NUM_SAMPLES - 1;

    logic signed [SAMPLE_W-1:0] mem [NUM_SAMPLES];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_vld_reg, rd_vld_next;
    logic [NUM_SAMPLES-1:0]     vld_reg, vld_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] old_sample;

    // An entry never written reads as zero, which is its reset value.
    assign old_sample = rd_vld_reg ? rd_data_reg : '0;

    // Running sum, pointer and valid bits advance when a sample is written.
    always_comb
    begin
        sum_next    = sum_reg;
        ptr_next    = ptr_reg;
        vld_next    = vld_reg;
        rd_vld_next = rd_vld_reg;
        if (ctl.rd)
        begin
            rd_vld_next = vld_reg[ptr_reg];
        end
        if (ctl.wr)
        begin
            sum_next          = sum_reg + SUM_W'(ctl.sample) - SUM_W'(old_sample);
            vld_next[ptr_reg] = 1'b1;
            if (ptr_reg == PTR_W'(LAST))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end
    end

    // Sample memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[ptr_reg] <= ctl.sample;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            ptr_reg    <= '0;
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            sum_reg    <= sum_next;
            ptr_reg    <= ptr_next;
            vld_reg    <= vld_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    assign sum = sum_reg;

endmodule

@@ rtl/moving_average_calibrated_scaler.sv @@
// Moving-average sensor channel with min/max calibration and output range map.
//
// Request channel (req_valid, req_stall, req): each request is a data sample,
// a capture-minimum or a capture-maximum. A request is taken when req_valid is
// high and req_stall is low; req_stall is high while a request is in progress.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, held steady while rsp_stall is high. A finished response waits in
// the output register, so the next request is taken while it is pending.
// Configuration: the user writes out_min and out_max through cfg_wr_en,
// cfg_index and cfg_data only while the block is idle, which it does not enforce.
// Sequence: the window average comes from a reciprocal multiplication and is
// registered. A capture passes through the average states to the response. A
// sample first updates the window, then answers directly on a zero calibration
// span, after a clamp check otherwise, and through the 24-step restoring
// divider when the range map divides; the unused request code skips the window
// update and is otherwise handled as a sample. Requests are taken one at a time.
// Reset clears the sample window (through per-entry valid bits), the running
// sum and pointer, and restores the calibration and output range defaults.
// A stalled receiver holds the last result; a new result that finishes first
// waits in the sequencer until the output register is free.
module moving_average_calibrated_scaler #(
    parameter int NUM_SAMPLES = macs_pkg::NUM_SAMPLES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  macs_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output macs_pkg::rsp_t                 rsp,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_index,
    input  logic [macs_pkg::CFG_W-1:0]     cfg_data
);
    import macs_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(NUM_SAMPLES);
    localparam int BIAS  = NUM_SAMPLES * 32768;
    localparam int N_W   = VALUE_W + 2;
    localparam int PRD_W = QUO_W + CFG_W;
    localparam int DLT_W = CFG_W + 1;

    // Rounded-up reciprocal of the window depth; exact for every biased sum.
    localparam int     AVG_S       = $clog2(NUM_SAMPLES);
    localparam int     AVG_SHIFT   = VALUE_W + AVG_S;
    localparam int     RCP_W       = 33;
    localparam int     APR_W       = SUM_W + RCP_W;
    localparam longint AVG_RECIP_L = ((longint'(1) << (AVG_SHIFT + 8)) +
                                      longint'(NUM_SAMPLES) - 1) / longint'(NUM_SAMPLES);
    localparam logic [RCP_W-1:0] AVG_RECIP = RCP_W'(AVG_RECIP_L);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_UPD        = 4'd1;
    localparam logic [3:0] ST_AVG        = 4'd2;
    localparam logic [3:0] ST_AVG_DONE   = 4'd3;
    localparam logic [3:0] ST_MAP_PREP   = 4'd4;
    localparam logic [3:0] ST_MAP_DECIDE = 4'd5;
    localparam logic [3:0] ST_MAP_DIV    = 4'd6;
    localparam logic [3:0] ST_MAP_WAIT   = 4'd7;
    localparam logic [3:0] ST_DONE       = 4'd8;

    logic [3:0]                 state_reg, state_next;
    logic [REQ_W-1:0]           req_type_reg, req_type_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic signed [VALUE_W-1:0]  avg_reg, avg_next;
    logic signed [N_W-1:0]      n_reg, n_next;
    logic signed [N_W-1:0]      d_reg, d_next;
    logic [PRD_W-1:0]           prod_reg, prod_next;
    logic                       neg_reg, neg_next;
    logic [REQ_W-1:0]           kind_reg, kind_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic                       warn_reg, warn_next;
    logic signed [VALUE_W-1:0]  cal_min_reg, cal_min_next;
    logic signed [VALUE_W-1:0]  cal_max_reg, cal_max_next;
    logic signed [CFG_W-1:0]    out_min_reg, out_min_next;
    logic signed [CFG_W-1:0]    out_max_reg, out_max_next;
    rsp_t                       rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                       accept;
    win_ctl_t                   win_ctl;
    logic signed [SUM_W-1:0]    win_sum;
    logic [SUM_W-1:0]           biased_sum;
    logic [APR_W-1:0]           avg_prod;
    div_ctl_t                   div_ctl;
    div_sts_t                   div_sts;
    logic signed [VALUE_W-1:0]  avg_q;
    logic signed [VALUE_W-1:0]  out_min_q8;
    logic signed [VALUE_W-1:0]  out_max_q8;
    logic signed [N_W-1:0]      n_raw;
    logic signed [N_W-1:0]      d_raw;
    logic signed [DLT_W-1:0]    delta;
    logic [DLT_W-1:0]           delta_abs;
    logic signed [N_W-1:0]      q_ext;
    logic signed [N_W-1:0]      offset;
    logic signed [N_W-1:0]      mapped;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);

    // Sample window and running sum.
    assign win_ctl.rd     = accept && (req.req_type == REQ_SAMPLE);
    assign win_ctl.wr     = (state_reg == ST_UPD);
    assign win_ctl.sample = sample_reg;

    macs_window #(
        .NUM_SAMPLES (NUM_SAMPLES)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (win_ctl),
        .sum   (win_sum)
    );

    // The average is taken from a sum offset to be non-negative, multiplied by
    // the reciprocal of the depth; the offset comes back out as a flip of the
    // top bit of the quotient.
    assign biased_sum = $unsigned(win_sum) + SUM_W'(BIAS);
    assign avg_prod   = biased_sum * AVG_RECIP;
    assign avg_q      = $signed(avg_prod[AVG_SHIFT +: VALUE_W] ^
                                {1'b1, {(VALUE_W-1){1'b0}}});

    // Divider for the range map.
    always_comb
    begin
        div_ctl.start    = (state_reg == ST_MAP_DIV);
        div_ctl.dividend = DIVD_W'({prod_reg, 8'h00});
        div_ctl.divisor  = d_reg[DIVS_W-1:0];
    end

    macs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sts   (div_sts)
    );

    // Range-map arithmetic.
    assign out_min_q8 = {out_min_reg, 8'h00};
    assign out_max_q8 = {out_max_reg, 8'h00};
    assign n_raw      = N_W'(avg_reg) - N_W'(cal_min_reg);
    assign d_raw      = N_W'(cal_max_reg) - N_W'(cal_min_reg);
    assign delta      = DLT_W'(out_max_reg) - DLT_W'(out_min_reg);
    assign delta_abs  = delta[DLT_W-1] ? $unsigned(-delta) : $unsigned(delta);
    assign q_ext      = $signed(N_W'(div_sts.quotient)) + $signed(N_W'(div_sts.rem_nz));
    assign offset     = neg_reg ? -q_ext : $signed(N_W'(div_sts.quotient));
    assign mapped     = N_W'(out_min_q8) + offset;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        req_type_next  = req_type_reg;
        sample_next    = sample_reg;
        avg_next       = avg_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        warn_next      = warn_reg;
        cal_min_next   = cal_min_reg;
        cal_max_next   = cal_max_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OUT_MIN: out_min_next = $signed(cfg_data);
                CFG_OUT_MAX: out_max_next = $signed(cfg_data);
                default:     out_min_next = out_min_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_type_next = req.req_type;
                    sample_next   = req.sample;
                    if (req.req_type == REQ_SAMPLE)
                    begin
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        state_next = ST_AVG;
                    end
                end
            end
            ST_UPD:
            begin
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                avg_next   = avg_q;
                state_next = ST_AVG_DONE;
            end
            ST_AVG_DONE:
            begin
                if (req_type_reg == REQ_CAP_MIN)
                begin
                    kind_next    = KIND_MIN;
                    value_next   = avg_reg;
                    warn_next    = (avg_reg >= cal_max_reg);
                    cal_min_next = avg_reg;
                    state_next   = ST_DONE;
                end
                else if (req_type_reg == REQ_CAP_MAX)
                begin
                    kind_next    = KIND_MAX;
                    value_next   = avg_reg;
                    warn_next    = (avg_reg <= cal_min_reg);
                    cal_max_next = avg_reg;
                    state_next   = ST_DONE;
                end
                else
                begin
                    state_next = ST_MAP_PREP;
                end
            end
            ST_MAP_PREP:
            begin
                kind_next = KIND_DATA;
                warn_next = 1'b0;
                if (d_raw == '0)
                begin
                    // Zero calibration span: a step at the calibration point.
                    value_next = (avg_reg >= cal_max_reg) ? out_max_q8 : out_min_q8;
                    state_next = ST_DONE;
                end
                else
                begin
                    // A reversed calibration inverts the mapping.
                    n_next     = d_raw[N_W-1] ? -n_raw : n_raw;
                    d_next     = d_raw[N_W-1] ? -d_raw : d_raw;
                    state_next = ST_MAP_DECIDE;
                end
            end
            ST_MAP_DECIDE:
            begin
                if (n_reg <= $signed(N_W'(0)))
                begin
                    value_next = out_min_q8;
                    state_next = ST_DONE;
                end
                else if (n_reg >= d_reg)
                begin
                    value_next = out_max_q8;
                    state_next = ST_DONE;
                end
                else
                begin
                    prod_next  = n_reg[QUO_W-1:0] * delta_abs[CFG_W-1:0];
                    neg_next   = delta[DLT_W-1];
                    state_next = ST_MAP_DIV;
                end
            end
            ST_MAP_DIV:
            begin
                state_next = ST_MAP_WAIT;
            end
            ST_MAP_WAIT:
            begin
                if (div_sts.done)
                begin
                    value_next = mapped[VALUE_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.kind          = kind_reg;
                    rsp_next.value         = value_reg;
                    rsp_next.order_warning = warn_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        sample_reg   <= sample_next;
        avg_reg      <= avg_next;
        n_reg        <= n_next;
        d_reg        <= d_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        kind_reg     <= kind_next;
        value_reg    <= value_next;
        warn_reg     <= warn_next;
        rsp_reg      <= rsp_next;
    end

    // Control, calibration and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cal_min_reg   <= CAL_MIN_RESET;
            cal_max_reg   <= CAL_MAX_RESET;
            out_min_reg   <= OUT_MIN_RESET;
            out_max_reg   <= OUT_MAX_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cal_min_reg   <= cal_min_next;
            cal_max_reg   <= cal_max_next;
            out_min_reg   <= out_min_next;
            out_max_reg   <= out_max_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The divider is only ever loaded when it has finished its last run.
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_sts.busy)
        else $error("divider loaded while busy");

    // A taken request closes the request channel on the next cycle.
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> req_stall)
        else $error("request channel open after a request was taken");

    // A data update never carries an order warning.
    a_data_no_warn: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.kind == KIND_DATA)) |-> !rsp.order_warning)
        else $error("order warning on a data update");

endmodule

@@ dv/moving_average_calibrated_scaler_tb.sv @@
module moving_average_calibrated_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import macs_pkg::*;

    localparam int WINDOW_DEPTH = NUM_SAMPLES_DEFAULT;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);

    // Request code that the block treats as a plain re-evaluation of the average.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Independent model of the channel: window, running sum, calibration and range.
    class scaled_average_ledger;
        logic signed [SAMPLE_W-1:0] slots [WINDOW_DEPTH];
        int unsigned                wr_slot;
        logic signed [SUM_W-1:0]    win_sum;
        logic signed [VALUE_W-1:0]  cal_lo;
        logic signed [VALUE_W-1:0]  cal_hi;
        logic signed [CFG_W-1:0]    range_lo;
        logic signed [CFG_W-1:0]    range_hi;
        rsp_t                       expected_updates [$];
        int unsigned                fault_count;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            wr_slot     = 0;
            win_sum     = '0;
            cal_lo      = CAL_MIN_RESET;
            cal_hi      = CAL_MAX_RESET;
            range_lo    = OUT_MIN_RESET;
            range_hi    = OUT_MAX_RESET;
            fault_count = 0;
        endfunction

        function void set_range(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_OUT_MIN)
                range_lo = data;
            else
                range_hi = data;
        endfunction

        // Division by a positive divisor, rounding towards minus infinity.
        function longint floor_div(longint p, longint d);
            longint q;
            q = p / d;
            if ((p % d) != 0 && p < 0)
                q = q - 1;
            return q;
        endfunction

        function longint window_average();
            return floor_div(longint'(win_sum) * 256, WINDOW_DEPTH);
        endfunction

        // Linear map of the average from the calibration span onto the output range.
        function longint mapped_average(longint avg);
            longint n;
            longint d;
            longint lo;
            longint hi;
            lo = longint'(range_lo);
            hi = longint'(range_hi);
            n  = avg - longint'(cal_lo);
            d  = longint'(cal_hi) - longint'(cal_lo);
            if (d == 0)
                return ((avg >= longint'(cal_hi)) ? hi : lo) * 256;
            if (d < 0)
            begin
                n = -n;
                d = -d;
            end
            if (n <= 0)
                return lo * 256;
            if (n >= d)
                return hi * 256;
            return lo * 256 + floor_div(n * (hi - lo) * 256, d);
        endfunction

        // Called for every accepted request: advance the model and queue the update.
        function void take_request(req_t r);
            rsp_t                       want;
            longint                     avg;
            int unsigned                slot;
            logic signed [SAMPLE_W-1:0] s;
            want.kind          = KIND_DATA;
            want.order_warning = 1'b0;
            case (r.req_type)
                REQ_CAP_MIN:
                begin
                    avg                = window_average();
                    want.order_warning = (avg >= longint'(cal_hi));
                    cal_lo             = VALUE_W'(avg);
                    want.kind          = KIND_MIN;
                end
                REQ_CAP_MAX:
                begin
                    avg                = window_average();
                    want.order_warning = (avg <= longint'(cal_lo));
                    cal_hi             = VALUE_W'(avg);
                    want.kind          = KIND_MAX;
                end
                REQ_SAMPLE:
                begin
                    s             = r.sample;
                    slot          = wr_slot;
                    win_sum       = win_sum + s - slots[slot];
                    slots[slot]   = s;
                    wr_slot       = (slot + 1) % WINDOW_DEPTH;
                    avg           = mapped_average(window_average());
                end
                default:
                    avg = mapped_average(window_average());
            endcase
            want.value = VALUE_W'(avg);
            expected_updates.push_back(want);
        endfunction

        function void report(string what);
            fault_count++;
            if (fault_count <= 10)
                $display("%t mismatch: %s", $realtime, what);
        endfunction

        // Called for every accepted response: compare against the oldest update.
        function void check_update(rsp_t got);
            rsp_t want;
            if (expected_updates.size() == 0)
            begin
                report($sformatf("response with no request outstanding: kind %0d value %0d warn %0b",
                                 got.kind, got.value, got.order_warning));
                return;
            end
            want = expected_updates.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.order_warning !== want.order_warning)
                report($sformatf("kind %0d/%0d value %0d/%0d warn %0b/%0b (expected/actual)",
                                 want.kind, got.kind, want.value, got.value,
                                 want.order_warning, got.order_warning));
        endfunction

        function int outstanding();
            return expected_updates.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_stall;
    rsp_t             rsp;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               drift_level;

    scaled_average_ledger ledger = new();

    moving_average_calibrated_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // Every accepted response is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            ledger.check_update(rsp);
    end

    // Receiver back-pressure: stretches of free flow, light, heavy and periodic stalling.
    initial
    begin : stall_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        rsp_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (tick = 0; tick < span; tick++)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_stall = 1'b0;
                    1: rsp_stall = ($urandom_range(0, 99) < 30);
                    2: rsp_stall = ($urandom_range(0, 99) < 75);
                    default: rsp_stall = ((tick % 11) < 6);
                endcase
            end
        end
    end

    // Hard limit on the run length.
    initial
    begin
        #8_000_000;
        $display("moving_average_calibrated_scaler_tb: done, errors");
        $finish;
    end

    function automatic req_t make_req(logic [REQ_W-1:0] code, logic signed [SAMPLE_W-1:0] s);
        req_t r;
        r.req_type = code;
        r.sample   = s;
        return r;
    endfunction

    // Samples mostly follow a slowly moving level, so that captured bounds form real spans.
    function automatic logic signed [SAMPLE_W-1:0] next_sample();
        int v;
        if ($urandom_range(0, 19) == 0)
            drift_level = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 9) < 3)
            return SAMPLE_W'($urandom);
        v = drift_level + int'($urandom_range(0, 4096)) - 2048;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick       = $urandom_range(0, 99);
        r.sample   = SAMPLE_W'($urandom);
        if (pick < 80)
        begin
            r.req_type = REQ_SAMPLE;
            r.sample   = next_sample();
        end
        else if (pick < 87)
            r.req_type = REQ_CAP_MIN;
        else if (pick < 94)
            r.req_type = REQ_CAP_MAX;
        else
            r.req_type = REQ_UNUSED;
        return r;
    endfunction

    // Present one request from a falling edge and hold it until it is taken.
    task automatic send_request(input req_t r);
        req       = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        ledger.take_request(r);
        @(negedge clk);
    endtask

    // Stop sending and wait until every outstanding request has been answered.
    task automatic wait_drained();
        req_valid = 1'b0;
        while (ledger.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic write_range(input logic idx, input logic [CFG_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        ledger.set_range(idx, data);
    endtask

    initial
    begin : stimulus
        int                      phase;
        int                      k;
        int                      burst_left;
        int unsigned             gap;
        logic signed [CFG_W-1:0] lo;
        logic signed [CFG_W-1:0] hi;

        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_OUT_MIN;
        cfg_data    = '0;
        drift_level = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset state, extreme samples, reversed calibration, then a zero span.
        send_request(make_req(REQ_UNUSED, 16'sh0000));
        send_request(make_req(REQ_SAMPLE, 16'sh7FFF));
        send_request(make_req(REQ_SAMPLE, 16'sh8000));
        send_request(make_req(REQ_CAP_MAX, 16'sh7FFF));
        send_request(make_req(REQ_SAMPLE, 16'sh0000));
        send_request(make_req(REQ_CAP_MIN, 16'sh8000));
        send_request(make_req(REQ_SAMPLE, 16'sh0000));
        send_request(make_req(REQ_SAMPLE, 16'sh8000));
        send_request(make_req(REQ_UNUSED, 16'sh5555));

        // Full output range, then an ordinary calibration span.
        wait_drained();
        write_range(CFG_OUT_MIN, 16'sh8000);
        write_range(CFG_OUT_MAX, 16'sh7FFF);
        repeat (6) send_request(make_req(REQ_SAMPLE, 16'sh7FFF));
        send_request(make_req(REQ_CAP_MAX, 16'sh0000));
        repeat (4) send_request(make_req(REQ_SAMPLE, 16'sh8000));
        send_request(make_req(REQ_CAP_MIN, 16'shFFFF));
        send_request(make_req(REQ_SAMPLE, 16'sd1000));
        send_request(make_req(REQ_SAMPLE, -16'sd1000));
        send_request(make_req(REQ_UNUSED, 16'shAAAA));

        // Random phases, each with its own output range, sent in bursts with gaps.
        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = 16'sh7FFF;
                    hi = 16'sh8000;
                end
                1:
                begin
                    lo = '0;
                    hi = '0;
                end
                2:
                begin
                    lo = 16'sh8000;
                    hi = 16'sh7FFF;
                end
                4:
                begin
                    lo = 16'sh8000;
                    hi = 16'sh8000;
                end
                6:
                begin
                    lo = OUT_MIN_RESET;
                    hi = OUT_MAX_RESET;
                end
                default:
                begin
                    lo = CFG_W'($urandom);
                    hi = CFG_W'($urandom);
                end
            endcase
            wait_drained();
            write_range(CFG_OUT_MIN, lo);
            write_range(CFG_OUT_MAX, hi);
            burst_left = 0;
            for (k = 0; k < 150; k++)
            begin
                if (burst_left == 0)
                begin
                    req_valid = 1'b0;
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    repeat (gap) @(negedge clk);
                    if ($urandom_range(0, 39) == 0)
                        wait_drained();
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                end
                send_request(random_request());
                burst_left--;
            end
        end

        // Let the last responses through and watch for strays.
        wait_drained();
        repeat (80) @(posedge clk);
        if (ledger.outstanding() != 0)
            ledger.report($sformatf("%0d responses never arrived", ledger.outstanding()));
        if (ledger.fault_count == 0)
            $display("moving_average_calibrated_scaler_tb: done, clean");
        else
            $display("moving_average_calibrated_scaler_tb: done, errors");
        $finish;
    end

endmodule
